### hdl/spn_pkg.sv
package spn_pkg;

   // Fixed geometry of the generator
   localparam int ROWS         = 16;
   localparam int RANDOM_BITS  = 24;
   localparam int SAMPLE_BITS  = 16;
   localparam int ROW_SEL_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SUM_BITS     = RANDOM_BITS + $clog2(ROWS + 1);
   localparam int MAG_BITS     = SUM_BITS - 1;

   // Congruential generator
   localparam int LCG_BITS = 32;
   localparam logic [LCG_BITS-1:0] LCG_MUL = 32'd196314165;
   localparam logic [LCG_BITS-1:0] LCG_ADD = 32'd907633515;

   // Shared multiplier
   localparam int MUL_BITS  = 32;
   localparam int PROD_BITS = 2 * MUL_BITS;

   // Scaling: |v| * volume * SMP_MAX / ((ROWS+1) * 2^(RANDOM_BITS+13))
   localparam int VOL_BITS    = 16;
   localparam int PV_BITS     = MAG_BITS + VOL_BITS;
   localparam int SCALED_BITS = PV_BITS + SAMPLE_BITS - 1;
   localparam int DIV_SHIFT   = RANDOM_BITS + 13;
   localparam int T_BITS      = SCALED_BITS - DIV_SHIFT;
   localparam int Q_BITS      = T_BITS;
   localparam int RECIP_SHIFT = 30;
   localparam logic [MUL_BITS-1:0] RECIP =
      MUL_BITS'(((64'd1 << RECIP_SHIFT) + ROWS) / (ROWS + 1));
   localparam logic [MAG_BITS-1:0] MAG_LIMIT =
      MAG_BITS'((64'd1 * (ROWS + 1)) << (RANDOM_BITS - 1));

   // Magnitude and sample limits
   localparam int CAP_BITS = SAMPLE_BITS + 1;
   localparam logic [CAP_BITS-1:0] MAG_CAP   = CAP_BITS'(64'd1 << SAMPLE_BITS);
   localparam logic [CAP_BITS-1:0] POS_LIMIT =
      CAP_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic [CAP_BITS-1:0] NEG_LIMIT = CAP_BITS'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Register file
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int MODE_BITS     = 2;
   localparam logic [1:0] REG_SEED   = 2'd0;
   localparam logic [1:0] REG_VOLUME = 2'd1;
   localparam logic [1:0] REG_MODE   = 2'd2;
   localparam logic [VOL_BITS-1:0]  VOLUME_RESET = 16'd32768;
   localparam logic [MODE_BITS-1:0] MODE_MONO    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INVERT  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INDEP   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_IDX,
      S_ROW_MUL,
      S_ROW_ADD,
      S_ROW_UPD,
      S_WHT_MUL,
      S_WHT_ADD,
      S_VAL,
      S_ABS,
      S_SC_MUL,
      S_SC_SHF,
      S_DIV_MUL,
      S_DIV_END,
      S_OUT
   } seq_state_type;

   typedef enum logic [1:0] {
      OPS_NONE,
      OPS_LCG,
      OPS_SCALE,
      OPS_RECIP
   } mul_sel_type;

   // Commands from the sequencer to one channel's state
   typedef struct packed {
      logic bump;   // advance index, remove the selected row from the sum
      logic store;  // write the fresh draw into the row, add it to the sum
   } chan_cmd_type;

   typedef struct packed {
      mul_sel_type  mul_sel;
      chan_cmd_type cmd;
      logic         lcg_step;
      logic         take_val;
      logic         take_abs;
      logic         take_t;
      logic         take_res;
      logic         take_out;
   } seq_ctrl_type;

   function automatic logic signed [SUM_BITS-1:0] widen_draw(
      input logic signed [RANDOM_BITS-1:0] d);
      return {{(SUM_BITS-RANDOM_BITS){d[RANDOM_BITS-1]}}, d};
   endfunction

endpackage

### hdl/spn_ifs.sv
// Request channel: one tick per transaction
interface spn_req_if import spn_pkg::*; ();
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

// Response channel: one stereo sample per transaction
interface spn_rsp_if import spn_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          clipped;

   modport source (output valid, output left_sample, output right_sample,
                   output clipped, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input clipped, output ready);
endinterface

### hdl/spn_mul.sv
module spn_mul import spn_pkg::*; (
   input  logic                 clock,
   input  logic [MUL_BITS-1:0]  a,
   input  logic [MUL_BITS-1:0]  b,
   output logic [PROD_BITS-1:0] prod
);

   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;

   // Unsigned product, registered
   assign prod_in = PROD_BITS'(a) * PROD_BITS'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### hdl/spn_chan.sv
module spn_chan import spn_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  chan_cmd_type                  cmd,
   input  logic signed [RANDOM_BITS-1:0] draw,
   output logic signed [SUM_BITS-1:0]    sum,
   output logic                          idx_full
);

   logic [ROWS-1:0]                idx_ff, idx_in;
   logic [ROW_SEL_BITS-1:0]        sel_ff, sel_in;
   logic signed [RANDOM_BITS-1:0]  rows_ff [ROWS];
   logic signed [SUM_BITS-1:0]     sum_ff, sum_in;

   // Trailing zero count, capped at the last row
   function automatic logic [ROW_SEL_BITS-1:0] low_zeros(input logic [ROWS-1:0] v);
      logic [ROW_SEL_BITS-1:0] z;
      logic                    found;
      z     = '0;
      found = 1'b0;
      for (int i = 0; i < ROWS - 1; i++) begin
         if (!found) begin
            if (v[i]) begin
               found = 1'b1;
            end else begin
               z = z + ROW_SEL_BITS'(1);
            end
         end
      end
      return z;
   endfunction

   assign idx_in   = idx_ff + ROWS'(1);
   assign sel_in   = low_zeros(idx_in);
   assign idx_full = &idx_ff;

   // Running sum: drop the old row on bump, add the new draw on store
   always_comb begin
      sum_in = sum_ff;
      if (cmd.bump && !idx_full) begin
         sum_in = sum_ff - widen_draw(rows_ff[sel_in]);
      end else if (cmd.store) begin
         sum_in = sum_ff + widen_draw(draw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sel_ff <= '0;
         sum_ff <= '0;
         for (int i = 0; i < ROWS; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         if (cmd.bump) begin
            idx_ff <= idx_in;
            sel_ff <= sel_in;
         end
         sum_ff <= sum_in;
         if (cmd.store) begin
            rows_ff[sel_ff] <= draw;
         end
      end
   end

   assign sum = sum_ff;

   // A wrapping index replaces no row, so the sum holds
   a_wrap_keeps_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.bump && idx_full |=> idx_ff == '0 && sum_ff == $past(sum_ff))
      else $error("index wrap changed the running sum");

endmodule

### hdl/spn_seq.sv
module spn_seq import spn_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   spn_req_if.sink                       req_chan,
   spn_rsp_if.source                     rsp_chan,
   input  logic                          seed_load,
   input  logic [LCG_BITS-1:0]           seed_value,
   input  logic [VOL_BITS-1:0]           volume,
   input  logic [MODE_BITS-1:0]          mode,
   output chan_cmd_type                  left_cmd,
   output chan_cmd_type                  right_cmd,
   output logic signed [RANDOM_BITS-1:0] draw,
   input  logic signed [SUM_BITS-1:0]    left_sum,
   input  logic signed [SUM_BITS-1:0]    right_sum,
   input  logic                          left_full,
   input  logic                          right_full,
   output logic [MUL_BITS-1:0]           mul_a,
   output logic [MUL_BITS-1:0]           mul_b,
   input  logic [PROD_BITS-1:0]          prod
);

   seq_state_type state_ff, state_in;
   seq_ctrl_type  ctrl;

   logic [LCG_BITS-1:0]           lcg_ff, lcg_in;
   logic                          ch_ff, ch_in;
   logic signed [SUM_BITS-1:0]    val_ff, val_in, val_neg;
   logic                          neg_ff, neg_in;
   logic [MAG_BITS-1:0]           mag_ff, mag_in;
   logic [T_BITS-1:0]             t_ff, t_in;
   logic [CAP_BITS-1:0]           res_mag_ff [2];
   logic [CAP_BITS-1:0]           res_mag_in;
   logic                          res_neg_ff [2];
   logic                          res_neg_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic                          clip_ff, clip_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   logic                          indep;
   logic signed [SUM_BITS-1:0]    sum_sel;
   logic                          full_sel;
   logic [PV_BITS-1:0]            pv;
   logic [SCALED_BITS-1:0]        scaled;
   logic [Q_BITS-1:0]             quo;
   logic [CAP_BITS-1:0]           r_mag;
   logic                          r_neg;
   logic [SAMPLE_BITS:0]          left_sat, right_sat;

   // Saturate a sign and magnitude to a sample; top bit flags clipping
   function automatic logic [SAMPLE_BITS:0] clamp(input logic neg,
                                                  input logic [CAP_BITS-1:0] mag);
      logic [CAP_BITS-1:0] m;
      logic [CAP_BITS-1:0] n;
      logic                c;
      m = mag;
      c = 1'b0;
      if (neg) begin
         if (mag > NEG_LIMIT) begin
            c = 1'b1;
            m = NEG_LIMIT;
         end
         n = '0 - m;
      end else begin
         if (mag > POS_LIMIT) begin
            c = 1'b1;
            m = POS_LIMIT;
         end
         n = m;
      end
      return {c, n[SAMPLE_BITS-1:0]};
   endfunction

   assign accept   = req_chan.valid && req_chan.ready;
   assign indep    = mode[1];
   assign sum_sel  = ch_ff ? right_sum : left_sum;
   assign full_sel = ch_ff ? right_full : left_full;
   assign draw     = $signed(lcg_ff[LCG_BITS-1 -: RANDOM_BITS]);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_chan.tick) begin
               state_in = S_IDX;
            end
         end
         S_IDX:     state_in = full_sel ? S_WHT_MUL : S_ROW_MUL;
         S_ROW_MUL: state_in = S_ROW_ADD;
         S_ROW_ADD: state_in = S_ROW_UPD;
         S_ROW_UPD: state_in = S_WHT_MUL;
         S_WHT_MUL: state_in = S_WHT_ADD;
         S_WHT_ADD: state_in = S_VAL;
         S_VAL:     state_in = S_ABS;
         S_ABS:     state_in = S_SC_MUL;
         S_SC_MUL:  state_in = S_SC_SHF;
         S_SC_SHF:  state_in = S_DIV_MUL;
         S_DIV_MUL: state_in = S_DIV_END;
         S_DIV_END: state_in = (!ch_ff && indep) ? S_IDX : S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Control outputs per state
   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = OPS_NONE;
      case (state_ff)
         S_IDX:     ctrl.cmd.bump = 1'b1;
         S_ROW_MUL: ctrl.mul_sel  = OPS_LCG;
         S_ROW_ADD: ctrl.lcg_step = 1'b1;
         S_ROW_UPD: ctrl.cmd.store = 1'b1;
         S_WHT_MUL: ctrl.mul_sel  = OPS_LCG;
         S_WHT_ADD: ctrl.lcg_step = 1'b1;
         S_VAL:     ctrl.take_val = 1'b1;
         S_ABS:     ctrl.take_abs = 1'b1;
         S_SC_MUL:  ctrl.mul_sel  = OPS_SCALE;
         S_SC_SHF:  ctrl.take_t   = 1'b1;
         S_DIV_MUL: ctrl.mul_sel  = OPS_RECIP;
         S_DIV_END: ctrl.take_res = 1'b1;
         S_OUT:     ctrl.take_out = !rsp_valid_ff || rsp_chan.ready;
         default:   ctrl = '0;
      endcase
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign left_cmd  = ch_ff ? chan_cmd_type'('0) : ctrl.cmd;
   assign right_cmd = ch_ff ? ctrl.cmd : chan_cmd_type'('0);

   // Operand select for the shared multiplier
   always_comb begin
      case (ctrl.mul_sel)
         OPS_LCG: begin
            mul_a = lcg_ff;
            mul_b = LCG_MUL;
         end
         OPS_SCALE: begin
            mul_a = MUL_BITS'(mag_ff);
            mul_b = MUL_BITS'(volume);
         end
         OPS_RECIP: begin
            mul_a = MUL_BITS'(t_ff);
            mul_b = RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Value, magnitude, scaling and quotient datapath
   assign val_neg = -val_ff;
   assign pv      = prod[PV_BITS-1:0];
   assign scaled  = {pv, {(SAMPLE_BITS-1){1'b0}}} - {{(SAMPLE_BITS-1){1'b0}}, pv};
   assign quo     = prod[RECIP_SHIFT +: Q_BITS];

   always_comb begin
      lcg_in = lcg_ff;
      if (seed_load) begin
         lcg_in = seed_value;
      end else if (ctrl.lcg_step) begin
         lcg_in = prod[LCG_BITS-1:0] + LCG_ADD;
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (state_ff == S_IDLE) begin
         ch_in = 1'b0;
      end else if (ctrl.take_res && !ch_ff && indep) begin
         ch_in = 1'b1;
      end
   end

   assign val_in = ctrl.take_val ? (sum_sel + widen_draw(draw)) : val_ff;
   assign neg_in = ctrl.take_abs ? val_ff[SUM_BITS-1] : neg_ff;
   always_comb begin
      mag_in = mag_ff;
      if (ctrl.take_abs) begin
         mag_in = val_ff[SUM_BITS-1] ? val_neg[MAG_BITS-1:0] : val_ff[MAG_BITS-1:0];
      end
   end
   assign t_in = ctrl.take_t ? scaled[SCALED_BITS-1 -: T_BITS] : t_ff;

   // Channel magnitude capped at MAG_CAP, 2^SAMPLE_BITS
   assign res_mag_in = (quo > Q_BITS'(MAG_CAP)) ? MAG_CAP : quo[CAP_BITS-1:0];
   assign res_neg_in = neg_ff && (quo != '0);

   // Right sample per stereo mode
   always_comb begin
      case (mode)
         MODE_MONO: begin
            r_mag = res_mag_ff[0];
            r_neg = res_neg_ff[0];
         end
         MODE_INVERT: begin
            r_mag = res_mag_ff[0];
            r_neg = !res_neg_ff[0] && (res_mag_ff[0] != '0);
         end
         default: begin
            r_mag = res_mag_ff[1];
            r_neg = res_neg_ff[1];
         end
      endcase
   end

   assign left_sat  = clamp(res_neg_ff[0], res_mag_ff[0]);
   assign right_sat = clamp(r_neg, r_mag);

   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.take_out) begin
         left_in      = $signed(left_sat[SAMPLE_BITS-1:0]);
         right_in     = $signed(right_sat[SAMPLE_BITS-1:0]);
         clip_in      = left_sat[SAMPLE_BITS] || right_sat[SAMPLE_BITS];
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         lcg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         lcg_ff       <= lcg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      t_ff     <= t_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      clip_ff  <= clip_in;
      if (ctrl.take_res) begin
         res_mag_ff[ch_ff] <= res_mag_in;
         res_neg_ff[ch_ff] <= res_neg_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_sample  = left_ff;
   assign rsp_chan.right_sample = right_ff;
   assign rsp_chan.clipped      = clip_ff;

   a_tick_starts_left: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.tick |=> state_ff == S_IDX && !ch_ff)
      else $error("tick did not start the left channel");

   a_mag_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SC_MUL |-> mag_ff <= MAG_LIMIT)
      else $error("channel magnitude beyond the sum of all rows");

   a_res_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_END |=> res_mag_ff[$past(ch_ff)] <= MAG_CAP)
      else $error("scaled magnitude not capped");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && clip_ff |-> left_ff == SMP_MAX || left_ff == SMP_MIN ||
                                  right_ff == SMP_MAX || right_ff == SMP_MIN)
      else $error("clip flagged without a sample at a rail");

endmodule

### hdl/stereo_pink_noise_generator.sv
// Sequence: an accepted tick runs one channel pass in mono or inverted mode and a left
//   then right pass in independent mode; a channel whose index wraps skips the row update.
// One transaction at a time: a new tick is taken only once idle; the sequencer shares one
//   registered 32x32 multiplier between the generator draws, gain and division by 17.
// Reset: synchronous; index, rows and sums clear, generator loads seed 0, volume
//   32768, independent stereo mode. A tick of zero is taken and gives no response.
module stereo_pink_noise_generator import spn_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   spn_req_if.sink                  req_chan,
   spn_rsp_if.source                rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [LCG_BITS-1:0]  seed_ff, seed_in;
   logic [VOL_BITS-1:0]  volume_ff, volume_in;
   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic                 csr_write;
   logic [1:0]           csr_index;
   logic                 seed_load;

   chan_cmd_type                  left_cmd, right_cmd;
   logic signed [RANDOM_BITS-1:0] draw;
   logic signed [SUM_BITS-1:0]    left_sum, right_sum;
   logic                          left_full, right_full;
   logic [MUL_BITS-1:0]           mul_a, mul_b;
   logic [PROD_BITS-1:0]          prod;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign seed_load  = csr_write && (csr_index == REG_SEED);

   always_comb begin
      seed_in   = seed_ff;
      volume_in = volume_ff;
      mode_in   = mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SEED:   seed_in   = csr_pwdata[LCG_BITS-1:0];
            REG_VOLUME: volume_in = csr_pwdata[VOL_BITS-1:0];
            REG_MODE:   mode_in   = csr_pwdata[MODE_BITS-1:0];
            default:    seed_in   = seed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         volume_ff <= VOLUME_RESET;
         mode_ff   <= MODE_INDEP;
      end else begin
         seed_ff   <= seed_in;
         volume_ff <= volume_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_SEED:   csr_prdata = CSR_DATA_BITS'(seed_ff);
         REG_VOLUME: csr_prdata = CSR_DATA_BITS'(volume_ff);
         REG_MODE:   csr_prdata = CSR_DATA_BITS'(mode_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Shared multiplier
   spn_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Per-channel row state
   spn_chan u_left (
      .clock    (clock),
      .reset    (reset),
      .cmd      (left_cmd),
      .draw     (draw),
      .sum      (left_sum),
      .idx_full (left_full)
   );

   spn_chan u_right (
      .clock    (clock),
      .reset    (reset),
      .cmd      (right_cmd),
      .draw     (draw),
      .sum      (right_sum),
      .idx_full (right_full)
   );

   // Sequencer and output register
   spn_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .seed_load  (seed_load),
      .seed_value (csr_pwdata[LCG_BITS-1:0]),
      .volume     (volume_ff),
      .mode       (mode_ff),
      .left_cmd   (left_cmd),
      .right_cmd  (right_cmd),
      .draw       (draw),
      .left_sum   (left_sum),
      .right_sum  (right_sum),
      .left_full  (left_full),
      .right_full (right_full),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .prod       (prod)
   );

endmodule
